### rtl/mesh_point_delete_compaction_defines.svh
// Assertion macros shared by the checker of the mesh compaction block.
// Depends on nothing.
`ifndef MESH_POINT_DELETE_COMPACTION_DEFINES_SVH
`define MESH_POINT_DELETE_COMPACTION_DEFINES_SVH
// Implication checked at each clock edge outside reset.
`define MPDC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mesh compaction check failed");
// Implication whose consequent is checked in the next cycle.
`define MPDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mesh compaction check failed");
`endif

### rtl/mpdc_pkg.sv
// Package for the mesh compaction block: sizes, codes, queue entry type.
// Depends on nothing.
package mpdc_pkg;
    localparam int MaxPoints = 4096;
    localparam int PtW = 12;
    localparam int MaxPrimVerts = 32;
    localparam int BufW = 5;
    localparam int CntW = 6;
    localparam int QDepth = 4;
    localparam int QW = 2;

    typedef enum logic [1:0] {
        ACT_POINT = 2'd0, ACT_VERTEX = 2'd1, ACT_END = 2'd2, ACT_RESTART = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        KIND_POINT = 3'd0, KIND_VERTEX = 3'd1, KIND_PRIM = 3'd2,
        KIND_DROP = 3'd3, KIND_OVF = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CMD_POINT = 2'd0, CMD_VERTEX = 2'd1, CMD_END = 2'd2, CMD_RESTART = 2'd3
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t        code;
        logic             keep;
        logic [PtW-1:0]   vp;
        logic             closed;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0, ST_READ = 2'd1, ST_REPLAY = 2'd2, ST_RECORD = 2'd3
    } st_t;
endpackage

### rtl/mpdc_front.sv
// Front part: accepts input words, classifies them and queues commands.
// Depends on mpdc_pkg.
module mpdc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [1:0]     s_action,
    input  logic           s_keep,
    input  logic [11:0]    s_vertex_point,
    input  logic           s_closed,
    input  logic           s_valid,
    output logic           s_ready,
    output mpdc_pkg::cmd_t q_data,
    output logic           q_valid,
    input  logic           q_ready
);
    import mpdc_pkg::*;

    cmd_t           mem [QDepth];
    logic [QW:0]    cnt_reg, cnt_next;
    logic [QW-1:0]  wp_reg, rp_reg;
    logic           push, pop;
    cmd_t           in_cmd;

    always_comb begin
        in_cmd.code = cmd_code_t'(s_action);
        in_cmd.keep = s_keep;
        in_cmd.vp = s_vertex_point;
        in_cmd.closed = s_closed;
    end

    assign s_ready = (cnt_reg != (QW+1)'(QDepth));
    assign push = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_data = mem[rp_reg];
    assign cnt_next = cnt_reg + (QW+1)'(push) - (QW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= in_cmd;
    end
endmodule

### rtl/mpdc_back.sv
// Back part: remap table, primitive buffer and result sequencing.
// Depends on mpdc_pkg.
module mpdc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  mpdc_pkg::cmd_t q_data,
    input  logic           q_valid,
    output logic           q_ready,
    output logic [2:0]     m_kind,
    output logic [15:0]    m_old_index,
    output logic [15:0]    m_new_index,
    output logic [11:0]    m_remapped_point,
    output logic [15:0]    m_new_start,
    output logic [5:0]     m_vertex_count,
    output logic           m_closed_out,
    output logic           m_last,
    output logic           m_valid,
    input  logic           m_ready
);
    import mpdc_pkg::*;

    logic [PtW:0]   remap_mem [MaxPoints];
    logic [PtW-1:0] pbuf [MaxPrimVerts];

    st_t            st_reg, st_next;
    logic [12:0]    loaded_reg, kept_reg;
    logic [16:0]    oldv_reg, newv_reg;
    logic [15:0]    oldp_reg, newp_reg;
    logic [CntW-1:0] fill_reg, k_reg;
    logic           alive_reg, ovf_reg, closed_reg;
    logic [PtW:0]   rd_reg;
    logic [PtW-1:0] buf_rd_reg;

    logic           out_valid_reg;
    logic [2:0]     kind_reg;
    logic [15:0]    oi_reg, ni_reg, ns_reg;
    logic [11:0]    rpt_reg;
    logic [5:0]     vc_reg;
    logic           cl_reg, last_reg;

    logic           out_free, take, do_vtx, take_end, out_load, rd_en;
    logic [PtW-1:0] rd_addr;
    logic [16:0]    first_old;
    logic [CntW-1:0] k_next;
    logic [BufW-1:0] buf_addr;

    assign out_free = !out_valid_reg || m_ready;
    assign q_ready = (st_reg == ST_IDLE) && out_free;
    assign take = q_valid && q_ready;
    assign do_vtx = take && q_data.code == CMD_VERTEX;
    assign take_end = take && q_data.code == CMD_END;
    assign first_old = oldv_reg - 17'(fill_reg);
    assign k_next = (st_reg == ST_REPLAY && out_free) ? k_reg + 1'b1 : k_reg;
    assign rd_en = !(st_reg == ST_REPLAY && !out_free);
    assign out_load = (take && q_data.code == CMD_POINT && loaded_reg < 13'(MaxPoints)
                       && q_data.keep)
                      || (take_end && (ovf_reg || !alive_reg))
                      || ((st_reg == ST_REPLAY || st_reg == ST_RECORD) && out_free);

    always_comb begin
        st_next = st_reg;
        buf_addr = '0;
        rd_addr = buf_rd_reg;
        case (st_reg)
            ST_IDLE: begin
                if (q_data.code != CMD_END) rd_addr = q_data.vp;
                if (take_end) buf_addr = BufW'(1);
                if (do_vtx) st_next = ST_READ;
                if (take_end && !ovf_reg && alive_reg) begin
                    st_next = (fill_reg == '0) ? ST_RECORD : ST_REPLAY;
                end
            end
            ST_READ: st_next = ST_IDLE;
            ST_REPLAY: begin
                buf_addr = BufW'(k_next + 1'b1);
                if (out_free && k_reg == fill_reg - 1'b1) st_next = ST_RECORD;
            end
            ST_RECORD: if (out_free) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take && q_data.code == CMD_POINT && loaded_reg < 13'(MaxPoints)) begin
            remap_mem[loaded_reg[PtW-1:0]] <= {q_data.keep, kept_reg[PtW-1:0]};
        end
        if (rd_en) rd_reg <= remap_mem[rd_addr];
        if (do_vtx && fill_reg < CntW'(MaxPrimVerts)) pbuf[fill_reg[BufW-1:0]] <= q_data.vp;
        buf_rd_reg <= pbuf[buf_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            loaded_reg <= '0; kept_reg <= '0;
            oldv_reg <= '0; newv_reg <= '0;
            oldp_reg <= '0; newp_reg <= '0;
            fill_reg <= '0; k_reg <= '0;
            alive_reg <= 1'b1; ovf_reg <= 1'b0; closed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: begin
                    k_reg <= '0;
                    if (take) begin
                        case (q_data.code)
                            CMD_POINT: begin
                                if (loaded_reg < 13'(MaxPoints)) begin
                                    loaded_reg <= loaded_reg + 1'b1;
                                    if (q_data.keep) begin
                                        kept_reg <= kept_reg + 1'b1;
                                        kind_reg <= KIND_POINT;
                                        oi_reg <= 16'(loaded_reg);
                                        ni_reg <= 16'(kept_reg);
                                        rpt_reg <= '0; ns_reg <= '0; vc_reg <= '0;
                                        cl_reg <= 1'b0; last_reg <= 1'b1;
                                    end
                                end
                            end
                            CMD_VERTEX: begin
                                oldv_reg <= oldv_reg + 1'b1;
                                if ({1'b0, q_data.vp} >= loaded_reg) alive_reg <= 1'b0;
                                if (fill_reg < CntW'(MaxPrimVerts)) fill_reg <= fill_reg + 1'b1;
                                else ovf_reg <= 1'b1;
                            end
                            CMD_END: begin
                                closed_reg <= q_data.closed;
                                if (ovf_reg || !alive_reg) begin
                                    kind_reg <= ovf_reg ? KIND_OVF : KIND_DROP;
                                    oi_reg <= oldp_reg; ni_reg <= '0;
                                    rpt_reg <= '0; ns_reg <= '0; vc_reg <= fill_reg;
                                    cl_reg <= q_data.closed; last_reg <= 1'b1;
                                    oldp_reg <= oldp_reg + 1'b1;
                                    fill_reg <= '0; alive_reg <= 1'b1; ovf_reg <= 1'b0;
                                end
                            end
                            CMD_RESTART: begin
                                loaded_reg <= '0; kept_reg <= '0;
                                oldv_reg <= '0; newv_reg <= '0;
                                oldp_reg <= '0; newp_reg <= '0;
                                fill_reg <= '0; alive_reg <= 1'b1; ovf_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: if (!rd_reg[PtW]) alive_reg <= 1'b0;
                ST_REPLAY: begin
                    // The table entry of buffered vertex k_reg is held in rd_reg.
                    if (out_free) begin
                        kind_reg <= KIND_VERTEX;
                        oi_reg <= 16'(first_old + 17'(k_reg));
                        ni_reg <= 16'(newv_reg + 17'(k_reg));
                        rpt_reg <= rd_reg[PtW-1:0];
                        ns_reg <= '0; vc_reg <= '0; cl_reg <= 1'b0; last_reg <= 1'b0;
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_RECORD: begin
                    if (out_free) begin
                        kind_reg <= KIND_PRIM;
                        oi_reg <= oldp_reg; ni_reg <= newp_reg;
                        rpt_reg <= '0; ns_reg <= 16'(newv_reg); vc_reg <= fill_reg;
                        cl_reg <= closed_reg; last_reg <= 1'b1;
                        newv_reg <= newv_reg + 17'(fill_reg);
                        newp_reg <= newp_reg + 1'b1;
                        oldp_reg <= oldp_reg + 1'b1;
                        fill_reg <= '0; alive_reg <= 1'b1; ovf_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind = kind_reg;
    assign m_old_index = oi_reg;
    assign m_new_index = ni_reg;
    assign m_remapped_point = rpt_reg;
    assign m_new_start = ns_reg;
    assign m_vertex_count = vc_reg;
    assign m_closed_out = cl_reg;
    assign m_last = last_reg;
endmodule

### rtl/mesh_point_delete_compaction.sv
// Top level of the mesh compaction block with point index remapping.
// Depends on mpdc_pkg, mpdc_front and mpdc_back.
// Usage: input words arrive on s_valid/s_ready with s_action selecting a
// point keep flag, a primitive vertex, an end of primitive or a mesh restart.
// Results leave on m_valid/m_ready; m_last marks the final result of a word.
// A four-entry queue separates the accepting front from the working back.
// A point is handled in the back part's idle state; a vertex also passes the
// read state, as it reads the remap memory and checks its valid bit on the
// following cycle. An end word of a kept primitive replays one buffered
// vertex a cycle through the buffer and remap reads while the receiver
// does not stall, then passes the record state. Dropped and overflowed
// primitives are handled in the idle state. With the back part idle, m_valid
// rises after the queue, any replay or record state and the output register.
// Reset clears all counters and primitive state; the remap memory needs
// no clearing because entries at or above the loaded count are never used.
// When the receiver stalls, the output register holds its word, the back
// part waits, and the queue fills before s_ready drops.
module mesh_point_delete_compaction (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  s_action,
    input  logic        s_keep,
    input  logic [11:0] s_vertex_point,
    input  logic        s_closed,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [2:0]  m_kind,
    output logic [15:0] m_old_index,
    output logic [15:0] m_new_index,
    output logic [11:0] m_remapped_point,
    output logic [15:0] m_new_start,
    output logic [5:0]  m_vertex_count,
    output logic        m_closed_out,
    output logic        m_last,
    output logic        m_valid,
    input  logic        m_ready
);
    import mpdc_pkg::*;

    cmd_t q_data;
    logic q_valid, q_ready;

    mpdc_front u_front (
        .aclk, .aresetn, .s_action, .s_keep, .s_vertex_point, .s_closed,
        .s_valid, .s_ready, .q_data, .q_valid, .q_ready
    );

    mpdc_back u_back (
        .aclk, .aresetn, .q_data, .q_valid, .q_ready,
        .m_kind, .m_old_index, .m_new_index, .m_remapped_point, .m_new_start,
        .m_vertex_count, .m_closed_out, .m_last, .m_valid, .m_ready
    );
endmodule

### rtl/mpdc_checker.sv
// Port level checker for the mesh compaction block, bound to the top level.
// Depends on mpdc_pkg and mesh_point_delete_compaction_defines.svh.
`include "mesh_point_delete_compaction_defines.svh"
module mpdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [5:0]  m_vertex_count,
    input logic        m_last
);
    import mpdc_pkg::*;

    `MPDC_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind))
    `MPDC_ASSERT_IMP(a_kind, aclk, aresetn, m_valid, m_kind <= KIND_OVF)
    `MPDC_ASSERT_IMP(a_vtx_last, aclk, aresetn, m_valid && m_kind == KIND_VERTEX, !m_last)
    `MPDC_ASSERT_IMP(a_count, aclk, aresetn, m_valid, m_vertex_count <= 6'(MaxPrimVerts))
endmodule

bind mesh_point_delete_compaction mpdc_checker u_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_kind, .m_vertex_count, .m_last
);

### tb/mesh_point_delete_compaction_tb.sv
// Testbench for the mesh compaction block: directed and random mesh streams
// checked against a built-in predictor. Depends on mpdc_pkg and the RTL top.
`timescale 1ns / 100ps
module mesh_point_delete_compaction_tb;
    import mpdc_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [15:0] old_index;
        logic [15:0] new_index;
        logic [11:0] remapped_point;
        logic [15:0] new_start;
        logic [5:0]  vertex_count;
        logic        closed_out;
        logic        last;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [1:0]  s_action = '0;
    logic        s_keep = 1'b0;
    logic [11:0] s_vertex_point = '0;
    logic        s_closed = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  m_kind;
    logic [15:0] m_old_index;
    logic [15:0] m_new_index;
    logic [11:0] m_remapped_point;
    logic [15:0] m_new_start;
    logic [5:0]  m_vertex_count;
    logic        m_closed_out;
    logic        m_last;
    logic        m_valid;
    logic        m_ready = 1'b0;

    int errors = 0;
    int cycles = 0;
    int words_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    result_t pending_results[$];

    // Predictor state.
    logic        remap_ok [MaxPoints];
    logic [11:0] remap_new [MaxPoints];
    logic [12:0] pts_loaded;
    logic [12:0] pts_kept;
    logic [16:0] old_vtx;
    logic [16:0] new_vtx;
    logic [15:0] old_prim;
    logic [15:0] new_prim;
    logic [11:0] prim_pts [MaxPrimVerts];
    logic [5:0]  prim_fill;
    logic        prim_alive;
    logic        prim_ovf;

    mesh_point_delete_compaction u_top (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > 600000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word kind %0d old %0d", $time, m_kind, m_old_index);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_kind !== e.kind || m_old_index !== e.old_index
                    || m_new_index !== e.new_index || m_remapped_point !== e.remapped_point
                    || m_new_start !== e.new_start || m_vertex_count !== e.vertex_count
                    || m_closed_out !== e.closed_out || m_last !== e.last) begin
                    $display("%0t: expected k%0d o%0d n%0d rp%0d s%0d c%0d cl%0d l%0d",
                             $time, e.kind, e.old_index, e.new_index, e.remapped_point,
                             e.new_start, e.vertex_count, e.closed_out, e.last);
                    $display("%0t: actual   k%0d o%0d n%0d rp%0d s%0d c%0d cl%0d l%0d",
                             $time, m_kind, m_old_index, m_new_index, m_remapped_point,
                             m_new_start, m_vertex_count, m_closed_out, m_last);
                    errors++;
                end
            end
        end
    end

    task automatic add_result(kind_t k, logic [15:0] oi, logic [15:0] ni, logic [11:0] rp,
                              logic [15:0] st, logic [5:0] cnt, logic cl);
        result_t r;
        r = '{k, oi, ni, rp, st, cnt, cl, 1'b0};
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic clear_mesh_state();
        pts_loaded = '0;
        pts_kept = '0;
        old_vtx = '0;
        new_vtx = '0;
        old_prim = '0;
        new_prim = '0;
        prim_fill = '0;
        prim_alive = 1'b1;
        prim_ovf = 1'b0;
    endtask

    task automatic predict_compaction(act_t act, logic keep, logic [11:0] vp, logic cl);
        int prior_count;
        logic [16:0] first_old;
        prior_count = pending_results.size();
        case (act)
            ACT_POINT: begin
                if (pts_loaded < MaxPoints) begin
                    remap_ok[pts_loaded[11:0]] = keep;
                    remap_new[pts_loaded[11:0]] = pts_kept[11:0];
                    if (keep) begin
                        add_result(KIND_POINT, 16'(pts_loaded), 16'(pts_kept), '0, '0, '0, 1'b0);
                        pts_kept = pts_kept + 1'b1;
                    end
                    pts_loaded = pts_loaded + 1'b1;
                end
            end
            ACT_VERTEX: begin
                old_vtx = old_vtx + 1'b1;
                if (13'(vp) >= pts_loaded || !remap_ok[vp]) prim_alive = 1'b0;
                if (prim_fill < MaxPrimVerts) begin
                    prim_pts[prim_fill[4:0]] = vp;
                    prim_fill = prim_fill + 1'b1;
                end else begin
                    prim_ovf = 1'b1;
                end
            end
            ACT_END: begin
                if (prim_ovf) begin
                    add_result(KIND_OVF, old_prim, '0, '0, '0, prim_fill, cl);
                end else if (!prim_alive) begin
                    add_result(KIND_DROP, old_prim, '0, '0, '0, prim_fill, cl);
                end else begin
                    first_old = old_vtx - 17'(prim_fill);
                    for (int k = 0; k < prim_fill; k++)
                        add_result(KIND_VERTEX, 16'(first_old + 17'(k)), 16'(new_vtx + 17'(k)),
                                   remap_new[prim_pts[k]], '0, '0, 1'b0);
                    add_result(KIND_PRIM, old_prim, new_prim, '0, 16'(new_vtx), prim_fill, cl);
                    new_vtx = new_vtx + 17'(prim_fill);
                    new_prim = new_prim + 1'b1;
                end
                old_prim = old_prim + 1'b1;
                prim_fill = '0;
                prim_alive = 1'b1;
                prim_ovf = 1'b0;
            end
            default: clear_mesh_state();
        endcase
        if (pending_results.size() > prior_count)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    task automatic send_word(act_t act, logic keep, logic [11:0] vp, logic cl);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_keep <= keep;
        s_vertex_point <= vp;
        s_closed <= cl;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        predict_compaction(act, keep, vp, cl);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic send_prim(int nv, int range_hi);
        for (int i = 0; i < nv; i++)
            send_word(ACT_VERTEX, 1'($urandom), 12'($urandom_range(range_hi)), 1'($urandom));
        send_word(ACT_END, 1'($urandom), 12'($urandom), 1'($urandom));
    endtask

    task automatic test_directed();
        send_word(ACT_POINT, 1'b1, 12'hfff, 1'b0);
        send_word(ACT_POINT, 1'b0, 12'h000, 1'b1);
        send_word(ACT_POINT, 1'b1, 12'h000, 1'b0);
        send_word(ACT_POINT, 1'b1, 12'h000, 1'b0);
        send_word(ACT_END, 1'b0, 12'h000, 1'b1);
        send_word(ACT_VERTEX, 1'b0, 12'd0, 1'b0);
        send_word(ACT_VERTEX, 1'b0, 12'd2, 1'b0);
        send_word(ACT_VERTEX, 1'b0, 12'd3, 1'b0);
        send_word(ACT_END, 1'b0, 12'h000, 1'b1);
        send_word(ACT_VERTEX, 1'b0, 12'd0, 1'b0);
        send_word(ACT_VERTEX, 1'b0, 12'd1, 1'b0);
        send_word(ACT_END, 1'b0, 12'h000, 1'b0);
        send_word(ACT_VERTEX, 1'b0, 12'd2, 1'b0);
        send_word(ACT_VERTEX, 1'b0, 12'hfff, 1'b0);
        send_word(ACT_END, 1'b0, 12'h000, 1'b1);
        send_word(ACT_RESTART, 1'b1, 12'hfff, 1'b1);
        send_word(ACT_VERTEX, 1'b0, 12'd0, 1'b0);
        send_word(ACT_END, 1'b0, 12'h000, 1'b0);
        send_word(ACT_POINT, 1'b1, 12'h000, 1'b0);
        send_prim(33, 0);
        send_prim(32, 0);
        wait_drained();
    endtask

    // Loads a block of points, then uses unloaded and topmost loaded entries.
    task automatic test_full_table();
        send_word(ACT_RESTART, 1'b0, 12'h000, 1'b0);
        for (int i = 0; i < 40; i++)
            send_word(ACT_POINT, ($urandom_range(7) != 0), 12'($urandom), 1'($urandom));
        for (int i = 0; i < 6; i++) begin
            send_word(ACT_VERTEX, 1'b0, (i < 3) ? 12'hfff - 12'(i) : 12'd42 - 12'(i), 1'b0);
            send_word(ACT_END, 1'b0, 12'h000, 1'($urandom));
        end
        send_prim(3, 39);
        wait_drained();
    endtask

    task automatic test_random(int sidle, int rstall, int budget);
        int target;
        int npts;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        target = words_sent + budget;
        while (words_sent < target) begin
            if ($urandom_range(9) == 0) begin
                send_word(act_t'($urandom_range(3)), 1'($urandom), 12'($urandom), 1'($urandom));
            end else begin
                send_word(ACT_RESTART, 1'($urandom), 12'($urandom), 1'($urandom));
                npts = $urandom_range(2, 24);
                for (int i = 0; i < npts; i++)
                    send_word(ACT_POINT, ($urandom_range(4) != 0), 12'($urandom), 1'($urandom));
                repeat ($urandom_range(2, 6)) begin
                    if ($urandom_range(15) == 0) send_prim($urandom_range(33, 35), npts - 1);
                    else send_prim($urandom_range(0, 5), ($urandom_range(7) == 0) ? 4095 : npts);
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_pause_until_empty();
        send_word(ACT_VERTEX, 1'b0, 12'd0, 1'b0);
        send_word(ACT_END, 1'b0, 12'd0, 1'b1);
        wait_drained();
        send_prim(2, 3);
        wait_drained();
    endtask

    initial begin
        clear_mesh_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        test_random(0, 0, 32);
        test_pause_until_empty();
        test_random(64, 0, 32);
        test_random(0, 64, 32);
        test_random(22, 22, 32);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
